>>> sv/lea_rkg_pkg.sv
// Shared types, constants and helpers for the LEA round key generator.
// No dependencies; every other file refers to this package by scoped names.
package lea_rkg_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned KEY_W       = 64;
   localparam int unsigned NUM_KWORDS  = 8;
   localparam int unsigned NUM_RK      = 6;
   localparam int unsigned ROUND_W     = 5;
   localparam int unsigned DIDX_W      = 3;
   localparam int unsigned MODE_W      = 2;

   localparam int unsigned ROUNDS_KEY128 = 24;
   localparam int unsigned ROUNDS_KEY192 = 28;
   localparam int unsigned ROUNDS_KEY256 = 32;

   // Key size codes; the unused code behaves as a 256-bit key
   localparam logic [MODE_W-1:0] KEY_MODE_128 = 2'd0;
   localparam logic [MODE_W-1:0] KEY_MODE_192 = 2'd1;
   localparam logic [MODE_W-1:0] KEY_MODE_256 = 2'd2;

   localparam logic [ROUND_W-1:0] LAST_ROUND_128 = ROUND_W'(ROUNDS_KEY128 - 1);
   localparam logic [ROUND_W-1:0] LAST_ROUND_192 = ROUND_W'(ROUNDS_KEY192 - 1);
   localparam logic [ROUND_W-1:0] LAST_ROUND_256 = ROUND_W'(ROUNDS_KEY256 - 1);

   // Last delta index for each key size (delta index wraps at 4, 6 or 8)
   localparam logic [DIDX_W-1:0] DIDX_LAST_128 = 3'd3;
   localparam logic [DIDX_W-1:0] DIDX_LAST_192 = 3'd5;
   localparam logic [DIDX_W-1:0] DIDX_LAST_256 = 3'd7;

   localparam logic [WORD_W-1:0] DELTA [NUM_KWORDS] = '{
      32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
      32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
   };

   localparam logic [ROUND_W-1:0] WORD_ROT [NUM_RK] = '{
      5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17
   };

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;   // capture a new key
      logic step;   // compute one round into the output register
   } cmd_type;

   typedef struct packed {
      logic out_free;  // output register empty or being taken this cycle
      logic last;      // current round is the final one of the key
   } status_type;

   // Rotate a 32-bit word left; a count of zero leaves it unchanged
   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                input logic [ROUND_W-1:0] n);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} << n;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

endpackage

>>> sv/lea_rkg_if.sv
// Channel interfaces of the LEA round key generator: key input, round key
// output and key size register write. Depends on lea_rkg_pkg.
interface lea_rkg_req_if;
   logic                            valid;
   logic                            ready;
   logic [lea_rkg_pkg::KEY_W-1:0]   key_words_0_1;
   logic [lea_rkg_pkg::KEY_W-1:0]   key_words_2_3;
   logic [lea_rkg_pkg::KEY_W-1:0]   key_words_4_5;
   logic [lea_rkg_pkg::KEY_W-1:0]   key_words_6_7;

   modport source (output valid, key_words_0_1, key_words_2_3, key_words_4_5,
                   key_words_6_7, input ready);
   modport sink (input valid, key_words_0_1, key_words_2_3, key_words_4_5,
                 key_words_6_7, output ready);
endinterface

interface lea_rkg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lea_rkg_pkg::ROUND_W-1:0]   round_number;
   logic [lea_rkg_pkg::WORD_W-1:0]    round_key_0;
   logic [lea_rkg_pkg::WORD_W-1:0]    round_key_1;
   logic [lea_rkg_pkg::WORD_W-1:0]    round_key_2;
   logic [lea_rkg_pkg::WORD_W-1:0]    round_key_3;
   logic [lea_rkg_pkg::WORD_W-1:0]    round_key_4;
   logic [lea_rkg_pkg::WORD_W-1:0]    round_key_5;
   logic                              last_round;

   modport source (output valid, round_number, round_key_0, round_key_1,
                   round_key_2, round_key_3, round_key_4, round_key_5,
                   last_round, input ready);
   modport sink (input valid, round_number, round_key_0, round_key_1,
                 round_key_2, round_key_3, round_key_4, round_key_5,
                 last_round, output ready);
endinterface

interface lea_rkg_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lea_rkg_pkg::MODE_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> sv/lea_round_key_generator_unit.sv
// After a key is taken, one round key item is made per cycle while the output register is free;
// a key gives 24, 28 or 32 round key items (128/192/256-bit), one from each pass of the one-round datapath.
// The next key can be taken in the cycle after the last round is computed, not before.
// Synchronous active-high reset empties the output register and selects the 128-bit key size.
// Top level of the LEA round key generator; depends on lea_rkg_pkg, lea_rkg_if,
// lea_rkg_ctrl, lea_rkg_datapath and lea_rkg_top_regs.
module lea_round_key_generator_unit (
   input  logic              clock,
   input  logic              reset,
   lea_rkg_req_if.sink       req_ch,
   lea_rkg_rsp_if.source     rsp_ch,
   lea_rkg_csr_if.sink       csr_ch
);

   lea_rkg_pkg::cmd_type             cmd;
   lea_rkg_pkg::status_type          status;
   logic [lea_rkg_pkg::MODE_W-1:0]   mode;
   logic                             req_ready;

   assign req_ch.ready = req_ready;

   lea_rkg_top_regs u_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .mode  (mode)
   );

   lea_rkg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lea_rkg_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .mode          (mode),
      .key_words_0_1 (req_ch.key_words_0_1),
      .key_words_2_3 (req_ch.key_words_2_3),
      .key_words_4_5 (req_ch.key_words_4_5),
      .key_words_6_7 (req_ch.key_words_6_7),
      .rsp           (rsp_ch)
   );

endmodule

>>> sv/lea_rkg_ctrl.sv
// Controller of the LEA round key generator: idle/run sequencing.
// Depends on lea_rkg_pkg; drives commands to lea_rkg_datapath.
module lea_rkg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lea_rkg_pkg::status_type   status,
   output lea_rkg_pkg::cmd_type      cmd
);

   lea_rkg_pkg::state_type state_ff;
   lea_rkg_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lea_rkg_pkg::ST_IDLE: begin
            if (req_valid) state_in = lea_rkg_pkg::ST_RUN;
         end
         lea_rkg_pkg::ST_RUN: begin
            if (status.out_free && status.last) state_in = lea_rkg_pkg::ST_IDLE;
         end
         default: state_in = lea_rkg_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         lea_rkg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         lea_rkg_pkg::ST_RUN: begin
            cmd.step = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lea_rkg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/lea_rkg_datapath.sv
// Datapath of the LEA round key generator: key state, round and delta
// counters, one-round update and the output register. Depends on lea_rkg_pkg
// and lea_rkg_if.
module lea_rkg_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  lea_rkg_pkg::cmd_type             cmd,
   output lea_rkg_pkg::status_type          status,
   input  logic [lea_rkg_pkg::MODE_W-1:0]   mode,
   input  logic [lea_rkg_pkg::KEY_W-1:0]    key_words_0_1,
   input  logic [lea_rkg_pkg::KEY_W-1:0]    key_words_2_3,
   input  logic [lea_rkg_pkg::KEY_W-1:0]    key_words_4_5,
   input  logic [lea_rkg_pkg::KEY_W-1:0]    key_words_6_7,
   lea_rkg_rsp_if.source                    rsp
);

   localparam int unsigned W  = lea_rkg_pkg::WORD_W;
   localparam int unsigned NK = lea_rkg_pkg::NUM_KWORDS;
   localparam int unsigned NR = lea_rkg_pkg::NUM_RK;

   // Key state; in 256-bit mode the array is kept rotated so that the
   // window of six words for the current round always sits in slots 0..5
   logic [W-1:0]                         t_ff [NK];
   logic [W-1:0]                         t_in [NK];
   logic [lea_rkg_pkg::ROUND_W-1:0]      round_ff, round_in;
   logic [lea_rkg_pkg::DIDX_W-1:0]       didx_ff, didx_in;
   logic [lea_rkg_pkg::MODE_W-1:0]       mode_ff, mode_in;

   logic                                 out_valid_ff, out_valid_in;
   logic [lea_rkg_pkg::ROUND_W-1:0]      out_round_ff, out_round_in;
   logic [W-1:0]                         out_rk_ff [NR];
   logic [W-1:0]                         out_rk_in [NR];
   logic                                 out_last_ff, out_last_in;

   logic                                 is128, is192;
   logic [lea_rkg_pkg::ROUND_W-1:0]      last_round;
   logic [lea_rkg_pkg::DIDX_W-1:0]       didx_last;
   logic [W-1:0]                         delta;
   logic [W-1:0]                         nw [NR];

   // Decode key size; the unused code runs as a 256-bit key
   always_comb begin
      is128 = (mode_ff == lea_rkg_pkg::KEY_MODE_128);
      is192 = (mode_ff == lea_rkg_pkg::KEY_MODE_192);
      priority if (is128) begin
         last_round = lea_rkg_pkg::LAST_ROUND_128;
         didx_last  = lea_rkg_pkg::DIDX_LAST_128;
      end else if (is192) begin
         last_round = lea_rkg_pkg::LAST_ROUND_192;
         didx_last  = lea_rkg_pkg::DIDX_LAST_192;
      end else begin
         last_round = lea_rkg_pkg::LAST_ROUND_256;
         didx_last  = lea_rkg_pkg::DIDX_LAST_256;
      end
   end

   // Compute one round of six updated words
   always_comb begin
      delta = lea_rkg_pkg::DELTA[didx_ff];
      for (int j = 0; j < NR; j++) begin
         nw[j] = lea_rkg_pkg::rotl32(
                    W'(t_ff[j] + lea_rkg_pkg::rotl32(delta,
                       round_ff + lea_rkg_pkg::ROUND_W'(j))),
                    lea_rkg_pkg::WORD_ROT[j]);
      end
   end

   assign status.out_free = !out_valid_ff || rsp.ready;
   assign status.last     = (round_ff == last_round);

   // Next key state, counters and output register
   always_comb begin
      t_in         = t_ff;
      round_in     = round_ff;
      didx_in      = didx_ff;
      mode_in      = mode_ff;
      out_round_in = out_round_ff;
      out_rk_in    = out_rk_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp.ready;

      if (cmd.load) begin
         t_in[0]  = key_words_0_1[W-1:0];
         t_in[1]  = key_words_0_1[2*W-1:W];
         t_in[2]  = key_words_2_3[W-1:0];
         t_in[3]  = key_words_2_3[2*W-1:W];
         t_in[4]  = key_words_4_5[W-1:0];
         t_in[5]  = key_words_4_5[2*W-1:W];
         t_in[6]  = key_words_6_7[W-1:0];
         t_in[7]  = key_words_6_7[2*W-1:W];
         round_in = '0;
         didx_in  = '0;
         mode_in  = mode;
      end else if (cmd.step) begin
         // Advance counters
         round_in = round_ff + 1'b1;
         didx_in  = (didx_ff == didx_last) ? '0 : didx_ff + 1'b1;

         // Write back updated words
         priority if (is128) begin
            for (int j = 0; j < 4; j++) t_in[j] = nw[j];
         end else if (is192) begin
            for (int j = 0; j < NR; j++) t_in[j] = nw[j];
         end else begin
            // Shift the window on by six words
            t_in[0] = t_ff[6];
            t_in[1] = t_ff[7];
            for (int j = 0; j < NR; j++) t_in[j+2] = nw[j];
         end

         // Load the output register
         out_valid_in = 1'b1;
         out_round_in = round_ff;
         out_last_in  = status.last;
         if (is128) begin
            out_rk_in[0] = nw[0];
            out_rk_in[1] = nw[1];
            out_rk_in[2] = nw[2];
            out_rk_in[3] = nw[1];
            out_rk_in[4] = nw[3];
            out_rk_in[5] = nw[1];
         end else begin
            out_rk_in = nw;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         round_ff     <= '0;
         didx_ff      <= '0;
         mode_ff      <= lea_rkg_pkg::KEY_MODE_128;
      end else begin
         out_valid_ff <= out_valid_in;
         round_ff     <= round_in;
         didx_ff      <= didx_in;
         mode_ff      <= mode_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      out_round_ff <= out_round_in;
      out_rk_ff    <= out_rk_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.round_number = out_round_ff;
   assign rsp.round_key_0  = out_rk_ff[0];
   assign rsp.round_key_1  = out_rk_ff[1];
   assign rsp.round_key_2  = out_rk_ff[2];
   assign rsp.round_key_3  = out_rk_ff[3];
   assign rsp.round_key_4  = out_rk_ff[4];
   assign rsp.round_key_5  = out_rk_ff[5];
   assign rsp.last_round   = out_last_ff;

   // Never overwrite an item that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!out_valid_ff || rsp.ready))
      else $error("round computed while output item still pending");

   // Load and step never coincide
   a_load_step_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.step)
      else $error("load and step in the same cycle");

   // Delta index stays below its modulus
   a_didx_range: assert property (@(posedge clock) disable iff (reset)
      didx_ff <= didx_last)
      else $error("delta index out of range");

endmodule

>>> sv/lea_rkg_top_regs.sv
// Key size register of the LEA round key generator.
// Depends on lea_rkg_pkg and lea_rkg_if.
module lea_rkg_top_regs (
   input  logic                             clock,
   input  logic                             reset,
   lea_rkg_csr_if.sink                      csr,
   output logic [lea_rkg_pkg::MODE_W-1:0]   mode
);

   logic [lea_rkg_pkg::MODE_W-1:0] mode_ff;

   assign csr.ready = 1'b1;
   assign mode      = mode_ff;

   // Capture a register write
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lea_rkg_pkg::KEY_MODE_128;
      end else if (csr.valid) begin
         mode_ff <= csr.data;
      end
   end

endmodule
